// File: rtl/core/led_lamp_fault_masking_sequencer_top_macros.svh
// Assertion macros for the LED lamp sequencer checker.
// Expects signals named clk and rst in the scope of use.
`ifndef LED_LAMP_FAULT_MASKING_SEQUENCER_TOP_MACROS_SVH
`define LED_LAMP_FAULT_MASKING_SEQUENCER_TOP_MACROS_SVH

// sampled on clk, quiet while rst is high
`define LLFMS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("llfms assertion failed");

// sampled on clk, also active during reset
`define LLFMS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("llfms assertion failed");

`endif

// File: rtl/core/llfms_pkg.sv
// Shared types and constants of the LED lamp fault masking sequencer.
// No dependencies.
`default_nettype none

package llfms_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [6:0] FULL_DUTY    = 7'd100;
  localparam logic       KIND_CHANNEL = 1'b0;
  localparam logic       KIND_PIXEL   = 1'b1;

  typedef enum logic [2:0] {
    CFG_INTENSITY_DUTY = 3'd0,
    CFG_ON_DELAY       = 3'd1,
    CFG_OFF_DELAY      = 3'd2,
    CFG_ON_RAMP        = 3'd3,
    CFG_OFF_RAMP       = 3'd4,
    CFG_CHANNEL_MASK   = 3'd5,
    CFG_MATRIX_MASK    = 3'd6,
    CFG_PIXEL_COUNT    = 3'd7
  } llfms_cfg_t;

  typedef enum logic [1:0] {
    PH_RUN = 2'd0,
    PH_ON  = 2'd1,
    PH_OFF = 2'd2
  } llfms_phase_t;

  typedef enum logic [2:0] {
    BK_IDLE       = 3'd0,
    BK_PAIR_A     = 3'd1,
    BK_PAIR_B     = 3'd2,
    BK_RUN_PLAIN  = 3'd3,
    BK_RUN_MATRIX = 3'd4,
    BK_PIXEL      = 3'd5
  } llfms_back_state_t;

  typedef struct packed {
    logic [7:0]  elapsed;
    logic        lamp_request;
    logic [4:0]  derate_flags;
    logic [15:0] channel_faults;
    logic        n_minus_one;
  } llfms_tick_t;

  typedef struct packed {
    logic        command_kind;
    logic [15:0] target_channels;
    logic [4:0]  pixel_index;
    logic [6:0]  duty;
    logic [7:0]  rise_time;
    logic [7:0]  fall_time;
    logic        last;
  } llfms_cmd_t;

  typedef struct packed {
    logic        pair;
    logic [15:0] pair_a;
    logic [15:0] pair_b;
    logic        run;
    logic [15:0] run_plain;
    logic [15:0] run_matrix;
    logic [6:0]  target;
    logic [7:0]  rise;
    logic [7:0]  fall;
    logic [4:0]  pixels;
  } llfms_job_t;

endpackage

`default_nettype wire

// File: rtl/core/llfms_front.sv
// Front end: configuration registers, lamp state and tick classification.
// Depends on llfms_pkg; emits one job per tick that produces commands.
`default_nettype none

module llfms_front #(
  parameter int CHANNELS   = 16,
  parameter int MAX_PIXELS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [llfms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [llfms_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                              tick_valid,
  output logic                                   tick_ready,
  input  wire llfms_pkg::llfms_tick_t            tick_word,
  output logic                                   push,
  output llfms_pkg::llfms_job_t                  push_job,
  input  wire logic                              full
);
  import llfms_pkg::*;

  localparam logic [15:0] ChanLimit =
    (CHANNELS >= 16) ? 16'hFFFF : 16'((32'd1 << CHANNELS) - 32'd1);
  localparam int PixCap = (MAX_PIXELS > 31) ? 31 : MAX_PIXELS;

  logic [6:0]   intensity_duty;
  logic [7:0]   on_delay;
  logic [7:0]   off_delay;
  logic [7:0]   on_ramp;
  logic [7:0]   off_ramp;
  logic [15:0]  channel_mask;
  logic [15:0]  matrix_mask;
  logic [4:0]   pixel_count;

  logic [6:0]   current_target;
  llfms_phase_t phase;
  logic [15:0]  plain_channels;
  logic [15:0]  matrix_channels;
  logic [7:0]   on_timer;
  logic [7:0]   off_timer;

  logic [6:0]   target_next;
  llfms_phase_t phase_next;
  logic [15:0]  plain_channels_next;
  logic [15:0]  matrix_channels_next;
  logic [7:0]   on_timer_next;
  logic [7:0]   off_timer_next;
  logic [15:0]  ep;
  logic [15:0]  em;
  logic [8:0]   sum;
  logic [6:0]   duty_sat;
  logic [4:0]   pixels_sat;
  logic         derating;
  logic         accept;
  logic         enabled;
  llfms_job_t   job;

  assign tick_ready = !full;
  assign accept     = tick_valid && tick_ready;
  assign enabled    = (channel_mask != 16'd0);
  assign duty_sat   = (intensity_duty > FULL_DUTY) ? FULL_DUTY : intensity_duty;
  assign pixels_sat = (pixel_count > 5'(PixCap)) ? 5'(PixCap) : pixel_count;

  always_comb begin
    target_next          = tick_word.lamp_request ? duty_sat : 7'd0;
    phase_next           = phase;
    plain_channels_next  = plain_channels;
    matrix_channels_next = matrix_channels;
    on_timer_next        = on_timer;
    off_timer_next       = off_timer;
    ep                   = '0;
    em                   = '0;
    sum                  = '0;
    job                  = '0;
    derating             = (target_next != 7'd0) && (tick_word.derate_flags != 5'd0);

    if (current_target == 7'd0 && target_next != 7'd0) begin
      plain_channels_next  = (channel_mask ^ matrix_mask) & ChanLimit;
      matrix_channels_next = matrix_mask & ChanLimit;
      phase_next           = PH_ON;
    end else if (current_target != 7'd0 && target_next == 7'd0) begin
      phase_next = PH_OFF;
    end

    if (target_next != 7'd0) begin
      job.pair = 1'b1;
      if (derating) begin
        job.pair_a = plain_channels_next;
        job.pair_b = matrix_channels_next;
      end else begin
        ep = plain_channels_next & tick_word.channel_faults;
        em = matrix_channels_next & tick_word.channel_faults;
        if (tick_word.n_minus_one && (ep | em) != 16'd0) begin
          ep = plain_channels_next;
          em = matrix_channels_next;
        end
        plain_channels_next  = plain_channels_next ^ ep;
        matrix_channels_next = matrix_channels_next ^ em;
        job.pair_a = ep;
        job.pair_b = em;
      end
    end

    if (!derating) begin
      unique case (phase_next)
        PH_ON: begin
          sum           = {1'b0, on_timer} + {1'b0, tick_word.elapsed};
          on_timer_next = sum[8] ? 8'hFF : sum[7:0];
          if (on_timer_next >= on_delay) begin
            on_timer_next = 8'd0;
            phase_next    = PH_RUN;
          end
        end
        PH_OFF: begin
          sum            = {1'b0, off_timer} + {1'b0, tick_word.elapsed};
          off_timer_next = sum[8] ? 8'hFF : sum[7:0];
          if (off_timer_next >= off_delay) begin
            off_timer_next = 8'd0;
            phase_next     = PH_RUN;
          end
        end
        PH_RUN: begin
          job.run        = 1'b1;
          job.run_plain  = plain_channels_next;
          job.run_matrix = matrix_channels_next;
          job.target     = target_next;
          job.rise       = on_ramp;
          job.fall       = off_ramp;
          job.pixels     = pixels_sat;
        end
        default: begin
        end
      endcase
    end
  end

  assign push     = accept && enabled && (job.pair || job.run);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      intensity_duty <= '0;
      on_delay       <= '0;
      off_delay      <= '0;
      on_ramp        <= '0;
      off_ramp       <= '0;
      channel_mask   <= '0;
      matrix_mask    <= '0;
      pixel_count    <= '0;
    end else if (cfg_we) begin
      unique case (llfms_cfg_t'(cfg_index))
        CFG_INTENSITY_DUTY: intensity_duty <= cfg_data[6:0];
        CFG_ON_DELAY:       on_delay       <= cfg_data[7:0];
        CFG_OFF_DELAY:      off_delay      <= cfg_data[7:0];
        CFG_ON_RAMP:        on_ramp        <= cfg_data[7:0];
        CFG_OFF_RAMP:       off_ramp       <= cfg_data[7:0];
        CFG_CHANNEL_MASK:   channel_mask   <= cfg_data;
        CFG_MATRIX_MASK:    matrix_mask    <= cfg_data;
        CFG_PIXEL_COUNT:    pixel_count    <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_target  <= '0;
      phase           <= PH_RUN;
      plain_channels  <= '0;
      matrix_channels <= '0;
      on_timer        <= '0;
      off_timer       <= '0;
    end else if (accept && enabled) begin
      current_target  <= target_next;
      phase           <= phase_next;
      plain_channels  <= plain_channels_next;
      matrix_channels <= matrix_channels_next;
      on_timer        <= on_timer_next;
      off_timer       <= off_timer_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/llfms_queue.sv
// Two-entry job queue between front end and command sequencer.
// Depends on llfms_pkg for the job type.
`default_nettype none

module llfms_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire llfms_pkg::llfms_job_t push_job,
  output logic                       full,
  output logic                       head_valid,
  output llfms_pkg::llfms_job_t      head,
  input  wire logic                  pop
);
  import llfms_pkg::*;

  llfms_job_t  entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_pop;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/llfms_back.sv
// Back end: steps through one job and emits its commands one per cycle while cmd_ready allows.
// Depends on llfms_pkg; drives the registered command output.
`default_nettype none

module llfms_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  head_valid,
  input  wire llfms_pkg::llfms_job_t head,
  output logic                       pop,
  output logic                       cmd_valid,
  input  wire logic                  cmd_ready,
  output llfms_pkg::llfms_cmd_t      cmd_word
);
  import llfms_pkg::*;

  llfms_back_state_t state;
  llfms_back_state_t state_next;
  llfms_job_t        job;
  logic [4:0]        pix;
  logic              load;
  logic              emit;
  llfms_cmd_t        word_next;

  assign load = !cmd_valid || cmd_ready;
  assign pop  = (state == BK_IDLE) && head_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (head_valid) begin
          state_next = head.pair ? BK_PAIR_A : BK_RUN_PLAIN;
        end
      end
      BK_PAIR_A: begin
        if (load) state_next = BK_PAIR_B;
      end
      BK_PAIR_B: begin
        if (load) state_next = job.run ? BK_RUN_PLAIN : BK_IDLE;
      end
      BK_RUN_PLAIN: begin
        if (load) state_next = BK_RUN_MATRIX;
      end
      BK_RUN_MATRIX: begin
        if (load) state_next = (job.pixels != 5'd0) ? BK_PIXEL : BK_IDLE;
      end
      BK_PIXEL: begin
        if (load && pix == job.pixels) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    emit      = 1'b0;
    word_next = '0;
    unique case (state)
      BK_IDLE: begin
      end
      BK_PAIR_A: begin
        emit                      = 1'b1;
        word_next.command_kind    = KIND_CHANNEL;
        word_next.target_channels = job.pair_a;
      end
      BK_PAIR_B: begin
        emit                      = 1'b1;
        word_next.command_kind    = KIND_CHANNEL;
        word_next.target_channels = job.pair_b;
        word_next.last            = !job.run;
      end
      BK_RUN_PLAIN: begin
        emit                      = 1'b1;
        word_next.command_kind    = KIND_CHANNEL;
        word_next.target_channels = job.run_plain;
        word_next.duty            = job.target;
        word_next.rise_time       = job.rise;
        word_next.fall_time       = job.fall;
      end
      BK_RUN_MATRIX: begin
        emit                      = 1'b1;
        word_next.command_kind    = KIND_CHANNEL;
        word_next.target_channels = job.run_matrix;
        word_next.duty            = FULL_DUTY;
        word_next.last            = (job.pixels == 5'd0);
      end
      BK_PIXEL: begin
        emit                  = 1'b1;
        word_next.command_kind = KIND_PIXEL;
        word_next.pixel_index = pix;
        word_next.duty        = job.target;
        word_next.rise_time   = job.rise;
        word_next.fall_time   = job.fall;
        word_next.last        = (pix == job.pixels);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      cmd_valid <= 1'b0;
      pix       <= 5'd1;
    end else begin
      state <= state_next;
      if (load) begin
        cmd_valid <= emit;
      end
      if (state == BK_IDLE) begin
        pix <= 5'd1;
      end else if (state == BK_PIXEL && load) begin
        pix <= pix + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head;
    end
    if (load && emit) begin
      cmd_word <= word_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/led_lamp_fault_masking_sequencer_top.sv
// Top level of the LED lamp fault masking sequencer.
// Depends on llfms_pkg, llfms_front, llfms_queue and llfms_back.
//
//   port group   | dir | handshake          | word
//   tick_*       | in  | tick_valid/ready   | llfms_tick_t
//   cmd_*        | out | cmd_valid/ready    | llfms_cmd_t
//   cfg_*        | in  | cfg_we, no wait    | cfg_index, cfg_data
//
// A tick is taken while the two-entry job queue has room.
// The sequencer fetches a job while idle, then emits one command per cycle
// unless cmd_ready stalls: up to 4 + pixel_count commands, pixel_count capped
// at MAX_PIXELS (31 at most).
// Synchronous rst clears configuration, lamp state, queue and output.
// A stalled cmd_ready holds the output word; ticks queue until the queue fills.
`default_nettype none

module led_lamp_fault_masking_sequencer_top #(
  parameter int CHANNELS   = 16,
  parameter int MAX_PIXELS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [llfms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [llfms_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                              tick_valid,
  output logic                                   tick_ready,
  input  wire llfms_pkg::llfms_tick_t            tick_word,
  output logic                                   cmd_valid,
  input  wire logic                              cmd_ready,
  output llfms_pkg::llfms_cmd_t                  cmd_word
);
  import llfms_pkg::*;

  logic       push;
  llfms_job_t push_job;
  logic       full;
  logic       head_valid;
  llfms_job_t head;
  logic       pop;

  llfms_front #(
    .CHANNELS   (CHANNELS),
    .MAX_PIXELS (MAX_PIXELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .tick_valid (tick_valid),
    .tick_ready (tick_ready),
    .tick_word  (tick_word),
    .push       (push),
    .push_job   (push_job),
    .full       (full)
  );

  llfms_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  llfms_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd_word   (cmd_word)
  );

endmodule

`default_nettype wire

// File: rtl/core/llfms_checker.sv
// Port-level checks of the LED lamp sequencer, bound to the top level.
// Depends on llfms_pkg and the assertion macro header.
`default_nettype none

`include "led_lamp_fault_masking_sequencer_top_macros.svh"

module llfms_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  cmd_valid,
  input wire logic                  cmd_ready,
  input wire llfms_pkg::llfms_cmd_t cmd_word
);
  import llfms_pkg::*;

  `LLFMS_ASSERT(a_cmd_hold, cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_word))
  `LLFMS_ASSERT(a_pixel_shape, cmd_valid && cmd_word.command_kind == KIND_PIXEL |-> cmd_word.target_channels == 16'd0 && cmd_word.pixel_index != 5'd0)
  `LLFMS_ASSERT(a_channel_shape, cmd_valid && cmd_word.command_kind == KIND_CHANNEL |-> cmd_word.pixel_index == 5'd0)
  `LLFMS_ASSERT(a_duty_range, cmd_valid |-> cmd_word.duty <= FULL_DUTY)
  `LLFMS_ASSERT_ALWAYS(a_reset_quiet, rst |=> !cmd_valid)

endmodule

bind led_lamp_fault_masking_sequencer_top llfms_checker u_llfms_checker (.*);

`default_nettype wire
